// ===== rtl/core/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and code tables for the 3x3 LBP stream block.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIXEL_BITS      = 8;
   localparam int CODE_BITS       = 8;
   localparam int CFG_SIZE_BITS   = 11;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int CSR_DATA_BITS   = 32;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_MAX_HEIGHT  = 1024;
   localparam int MIN_SIZE        = 3;
   localparam int CODE_COUNT      = 256;

   localparam logic [CFG_SIZE_BITS-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CFG_SIZE_BITS-1:0] RESET_HEIGHT = 11'd480;

   // Register index, taken from paddr[3:2]. Index 3 holds no register.
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_CODE_MODE    = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_RAW      = 2'd0,
      MODE_RI_MIN   = 2'd1,
      MODE_RI_INDEX = 2'd2,
      MODE_UNIFORM  = 2'd3
   } code_mode_type;

   // Per-item position flags handed from the position counters downstream.
   typedef struct packed {
      logic emit;
      logic row_last;
      logic frame_last;
   } flags_type;

   typedef logic [CODE_BITS-1:0] lut_type [CODE_COUNT];

   function automatic logic [7:0] rot_right(input logic [7:0] v, input int n);
      logic [7:0] res;
      res = (v >> n) | (v << (8 - n));
      return res;
   endfunction

   function automatic logic [7:0] rot_min(input logic [7:0] v);
      logic [7:0] best;
      logic [7:0] t;
      best = v;
      for (int n = 1; n < 8; n++) begin
         t = rot_right(v, n);
         if (t < best) best = t;
      end
      return best;
   endfunction

   function automatic int hops(input logic [7:0] v);
      logic [7:0] d;
      int cnt;
      d = v ^ rot_right(v, 1);
      cnt = 0;
      for (int i = 0; i < 8; i++) cnt += int'(d[i]);
      return cnt;
   endfunction

   function automatic lut_type build_ri_min_lut();
      lut_type lut;
      for (int v = 0; v < CODE_COUNT; v++) lut[v] = rot_min(8'(v));
      return lut;
   endfunction

   // Position of the rotation minimum among all rotation minima, ascending.
   function automatic lut_type build_ri_index_lut();
      lut_type lut;
      logic [7:0] m;
      int idx;
      for (int v = 0; v < CODE_COUNT; v++) begin
         m = rot_min(8'(v));
         idx = 0;
         for (int u = 0; u < CODE_COUNT; u++) begin
            if (u < int'(m) && rot_min(8'(u)) == 8'(u)) idx++;
         end
         lut[v] = 8'(idx);
      end
      return lut;
   endfunction

   // Uniform codes get labels 1..58 in increasing code order, all others 0.
   function automatic lut_type build_uniform_lut();
      lut_type lut;
      int lab;
      lab = 1;
      for (int v = 0; v < CODE_COUNT; v++) begin
         if (hops(8'(v)) <= 2) begin
            lut[v] = 8'(lab);
            lab++;
         end else begin
            lut[v] = '0;
         end
      end
      return lut;
   endfunction

   localparam lut_type RI_MIN_LUT   = build_ri_min_lut();
   localparam lut_type RI_INDEX_LUT = build_ri_index_lut();
   localparam lut_type UNIFORM_LUT  = build_uniform_lut();

endpackage

// ===== rtl/core/lbp_ram.sv =====
// ----------------------------------------------------------------------------
// lbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/lbp_pos.sv =====
// ----------------------------------------------------------------------------
// lbp_pos
// Column and row counters with the row, frame and interior flags per item.
// ----------------------------------------------------------------------------
module lbp_pos #(
   parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [lbp_pkg::CFG_SIZE_BITS-1:0] width_cfg,
   input  logic [lbp_pkg::CFG_SIZE_BITS-1:0] height_cfg,
   output logic [$clog2(MAX_WIDTH)-1:0]      col,
   output lbp_pkg::flags_type                flags
);
   import lbp_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WCW = (CW + 1 > CFG_SIZE_BITS) ? CW + 1 : CFG_SIZE_BITS;
   localparam int HCW = (RW + 1 > CFG_SIZE_BITS) ? RW + 1 : CFG_SIZE_BITS;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [WCW-1:0] w_cfg, w_eff;
   logic [HCW-1:0] h_cfg, h_eff;
   logic           row_last, frame_last;

   // Sizes below the minimum act as the minimum, above the maximum as it.
   always_comb begin
      w_cfg = WCW'(width_cfg);
      h_cfg = HCW'(height_cfg);
      if (w_cfg < WCW'(MIN_SIZE)) begin
         w_eff = WCW'(MIN_SIZE);
      end else if (w_cfg > WCW'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      if (h_cfg < HCW'(MIN_SIZE)) begin
         h_eff = HCW'(MIN_SIZE);
      end else if (h_cfg > HCW'(MAX_HEIGHT)) begin
         h_eff = HCW'(MAX_HEIGHT);
      end else begin
         h_eff = h_cfg;
      end
   end

   always_comb begin
      row_last   = (WCW'(col_ff) + WCW'(1)) >= w_eff;
      frame_last = row_last && ((HCW'(row_ff) + HCW'(1)) >= h_eff);
      col_in     = col_ff;
      row_in     = row_ff;
      if (advance) begin
         if (row_last) begin
            col_in = '0;
            row_in = frame_last ? '0 : RW'(row_ff + RW'(1));
         end else begin
            col_in = CW'(col_ff + CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col              = col_ff;
   assign flags.emit       = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
   assign flags.row_last   = row_last;
   assign flags.frame_last = frame_last;

endmodule

// ===== rtl/core/lbp_window.sv =====
// ----------------------------------------------------------------------------
// lbp_window
// Two past columns of the 3x3 window and the eight neighbour comparisons.
// ----------------------------------------------------------------------------
module lbp_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [lbp_pkg::PIXEL_BITS-1:0] top,
   input  logic [lbp_pkg::PIXEL_BITS-1:0] mid,
   input  logic [lbp_pkg::PIXEL_BITS-1:0] pixel,
   output logic [lbp_pkg::CODE_BITS-1:0]  raw_code
);
   import lbp_pkg::*;

   // Entries 0..2 are the newer column (top, middle, bottom), 3..5 the older.
   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [PIXEL_BITS-1:0] ctr;

   assign ctr = win_ff[1];

   // Top-left is bit 7, then clockwise around the centre.
   always_comb begin
      raw_code[7] = win_ff[3] >= ctr;
      raw_code[6] = win_ff[0] >= ctr;
      raw_code[5] = top       >= ctr;
      raw_code[4] = mid       >= ctr;
      raw_code[3] = pixel     >= ctr;
      raw_code[2] = win_ff[2] >= ctr;
      raw_code[1] = win_ff[5] >= ctr;
      raw_code[0] = win_ff[4] >= ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (advance) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= pixel;
      end
   end

endmodule

// ===== rtl/core/lbp_encoder.sv =====
// ----------------------------------------------------------------------------
// lbp_encoder
// Maps a raw pattern code to the output code selected by the mode register.
// ----------------------------------------------------------------------------
module lbp_encoder (
   input  logic [lbp_pkg::CODE_BITS-1:0] raw_code,
   input  lbp_pkg::code_mode_type        mode,
   output logic [lbp_pkg::CODE_BITS-1:0] code
);
   import lbp_pkg::*;

   always_comb begin
      case (mode)
         MODE_RAW:      code = raw_code;
         MODE_RI_MIN:   code = RI_MIN_LUT[raw_code];
         MODE_RI_INDEX: code = RI_INDEX_LUT[raw_code];
         MODE_UNIFORM:  code = UNIFORM_LUT[raw_code];
         default:       code = raw_code;
      endcase
   end

endmodule

// ===== rtl/core/lbp_3x3_stream_multimode_top.sv =====
// ----------------------------------------------------------------------------
// lbp_3x3_stream_multimode_top
// 3x3 local binary pattern over a raster pixel stream, four code modes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                         Moves
//   req       in         req_valid/ready, req_pixel    one grey pixel per item
//   rsp       out        rsp_valid/ready, rsp_code,    one code per interior
//                        rsp_row_end, rsp_frame_end    pixel
//   csr       in/out     psel, penable, pwrite, paddr, image size and mode
//                        pwdata, prdata, pready
//
// One pixel item is accepted per clock while no stalled result holds the
// middle stage. The line store read is launched in the accept cycle; the
// next cycle compares the window and encodes, and the code then moves into
// the result register when the middle stage moves on.
// Reset is synchronous; no clearing pass runs, stale line store data reaches
// only the first two rows of a frame, which give no result.
// A stalled result holds only the middle stage, and only when that stage
// carries a result; the input side stays open while that stage is empty.
//
module lbp_3x3_stream_multimode_top #(
   parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel items in.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lbp_pkg::PIXEL_BITS-1:0]    req_pixel,
   // Code items out.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lbp_pkg::CODE_BITS-1:0]     rsp_code,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   // Register port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lbp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [lbp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [lbp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import lbp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase.
   // ---------------------------------------------------------------------
   logic [CFG_SIZE_BITS-1:0] width_ff, width_in;
   logic [CFG_SIZE_BITS-1:0] height_ff, height_in;
   code_mode_type            mode_ff, mode_in;
   reg_index_type            csr_index;
   logic                     csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = pwdata[CFG_SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[CFG_SIZE_BITS-1:0];
            REG_CODE_MODE:    mode_in   = code_mode_type'(pwdata[1:0]);
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         mode_ff   <= MODE_RAW;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         REG_CODE_MODE:    prdata = CSR_DATA_BITS'(mode_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake and stage control.
   // The middle stage moves on unless it carries a result and the result
   // register is still full and not being taken.
   // ---------------------------------------------------------------------
   logic                  req_accept;
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [CW-1:0]         s1_col_ff;
   flags_type             s1_flags_ff;
   logic                  s1_adv;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]  rsp_code_ff;
   logic                  rsp_row_end_ff, rsp_frame_end_ff;
   logic                  rsp_load;

   assign s1_adv     = s1_valid_ff && (!s1_flags_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;
   assign rsp_load   = s1_adv && s1_flags_ff.emit;

   // ---------------------------------------------------------------------
   // Position counters: column for the line store, flags for the item.
   // ---------------------------------------------------------------------
   logic [CW-1:0] pos_col;
   flags_type     pos_flags;

   lbp_pos #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_accept),
      .width_cfg (width_ff),
      .height_cfg(height_ff),
      .col       (pos_col),
      .flags     (pos_flags)
   );

   // ---------------------------------------------------------------------
   // Line store: one word per column holds {two rows up, one row up}.
   // The read is launched at accept; the write-back of {one row up, new
   // pixel} happens when the item leaves the middle stage. Consecutive
   // items always sit in different columns, so read and write never meet.
   // ---------------------------------------------------------------------
   logic                      ram_we, ram_re;
   logic [CW-1:0]             ram_waddr, ram_raddr;
   logic [2*PIXEL_BITS-1:0]   ram_wdata, ram_rdata;
   logic [PIXEL_BITS-1:0]     line_top, line_mid;

   assign ram_re    = req_accept;
   assign ram_raddr = pos_col;
   assign ram_we    = s1_adv;
   assign ram_waddr = s1_col_ff;
   assign line_top  = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
   assign line_mid  = ram_rdata[PIXEL_BITS-1:0];
   assign ram_wdata = {line_mid, s1_pixel_ff};

   lbp_ram #(
      .WIDTH(2 * PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Middle stage: pixel, its column and its flags.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= pos_col;
         s1_flags_ff <= pos_flags;
      end
   end

   // ---------------------------------------------------------------------
   // Window, comparisons and code mapping.
   // ---------------------------------------------------------------------
   logic [CODE_BITS-1:0] raw_code;
   logic [CODE_BITS-1:0] enc_code;

   lbp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .top     (line_top),
      .mid     (line_mid),
      .pixel   (s1_pixel_ff),
      .raw_code(raw_code)
   );

   lbp_encoder u_encoder (
      .raw_code(raw_code),
      .mode    (mode_ff),
      .code    (enc_code)
   );

   // ---------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_code_ff      <= enc_code;
         rsp_row_end_ff   <= s1_flags_ff.row_last;
         rsp_frame_end_ff <= s1_flags_ff.frame_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_frame_implies_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_frame_end_ff || rsp_row_end_ff))
      else $error("frame end flagged without row end");

   a_no_ram_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("line store read and write at the same column");

   a_stall_only_on_blocked_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (s1_flags_ff.emit && rsp_valid_ff && !rsp_ready))
      else $error("middle stage held without a blocked result");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

endmodule

// ===== dv/lbp_3x3_stream_multimode_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_3x3_stream_multimode_top_test
// Self-checking bench for the 3x3 LBP stream block in all four code modes.
//
// Pixel items are queued by a sequencer, handed to the block by a clocked
// driver, and run through a local model of the window, line store and code
// encoders at the moment they are accepted. A clocked monitor pops one
// expected code item for every result and compares code, row end and frame
// end. Register settings change only while the block is quiet: between
// frames and, now and then, in the middle of a frame.
// ----------------------------------------------------------------------------
module lbp_3x3_stream_multimode_top_test;
   import lbp_pkg::*;

   localparam int MAX_W         = DEF_MAX_WIDTH;
   localparam int MAX_H         = DEF_MAX_HEIGHT;
   // Extra wait for the last accepted pixel to leave the block, with margin.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 400;
   localparam int IDLE_PCT      = 21;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 row_end;
      logic                 frame_end;
   } lbp_result_type;

   // Picture textures: flat and narrow ones create many equal neighbours,
   // binary ones push every comparison to its extreme.
   typedef enum int {
      TEX_UNIFORM,
      TEX_NARROW,
      TEX_BINARY,
      TEX_FLAT
   } texture_type;

   // ------------------------------------------------------------------------
   // Block ports. Every input has a known value from time zero.
   // ------------------------------------------------------------------------
   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIXEL_BITS-1:0]    req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CODE_BITS-1:0]     rsp_code;
   logic                     rsp_row_end;
   logic                     rsp_frame_end;
   logic                     psel      = 1'b0;
   logic                     penable   = 1'b0;
   logic                     pwrite    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr     = '0;
   logic [CSR_DATA_BITS-1:0] pwdata    = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   lbp_3x3_stream_multimode_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code      (rsp_code),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Local model state: register copies, line store, window and position.
   // ------------------------------------------------------------------------
   logic [CFG_SIZE_BITS-1:0] cfg_width  = RESET_WIDTH;
   logic [CFG_SIZE_BITS-1:0] cfg_height = RESET_HEIGHT;
   code_mode_type            cfg_mode   = MODE_RAW;
   logic [PIXEL_BITS-1:0]    line_mem [2*MAX_W];
   logic [PIXEL_BITS-1:0]    win [6];
   int unsigned              col_pos;
   int unsigned              row_pos;

   logic [PIXEL_BITS-1:0] pixel_queue [$];
   lbp_result_type        expected_codes [$];
   lbp_result_type        code_want;

   int stall_pct       = IDLE_PCT;
   int errors          = 0;
   int pixels_accepted = 0;
   int codes_checked   = 0;
   int frames_seen     = 0;
   int csr_writes      = 0;

   function automatic logic [7:0] rotate_right(input logic [7:0] v, input int n);
      logic [15:0] twice;
      twice = {v, v};
      return twice[n +: 8];
   endfunction

   function automatic logic [7:0] min_rotation(input logic [7:0] v);
      logic [7:0] best;
      logic [7:0] cand;
      best = v;
      for (int n = 1; n < 8; n++) begin
         cand = rotate_right(v, n);
         if (cand < best) best = cand;
      end
      return best;
   endfunction

   // Number of 0/1 changes going once around the ring of neighbours.
   function automatic int transitions(input logic [7:0] v);
      return $countones(v ^ rotate_right(v, 1));
   endfunction

   function automatic logic [7:0] encode_pattern(input logic [7:0] raw,
                                                 input code_mode_type mode);
      logic [7:0] m;
      int label;
      case (mode)
         MODE_RAW: begin
            return raw;
         end
         MODE_RI_MIN: begin
            return min_rotation(raw);
         end
         MODE_RI_INDEX: begin
            // The index is how many rotation minima lie below this one.
            m = min_rotation(raw);
            label = 0;
            for (int u = 0; u < int'(m); u++)
               if (min_rotation(8'(u)) == 8'(u)) label++;
            return 8'(label);
         end
         default: begin
            if (transitions(raw) > 2) return 8'd0;
            label = 1;
            for (int u = 0; u < int'(raw); u++)
               if (transitions(8'(u)) <= 2) label++;
            return 8'(label);
         end
      endcase
   endfunction

   // Sizes below three act as three, sizes above the build maximum act as it.
   function automatic int effective_size(input logic [CFG_SIZE_BITS-1:0] v,
                                         input int hi);
      if (v < 3) return 3;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // One accepted pixel: read both line store rows at this column, emit a code
   // for the centre one pixel up and left when it is interior, then shift.
   function automatic void advance_window(input logic [7:0] pix);
      int             w;
      int             h;
      int unsigned    ci;
      logic [7:0]     top;
      logic [7:0]     mid;
      logic [7:0]     ctr;
      logic [7:0]     raw;
      logic           row_last;
      logic           frame_last;
      lbp_result_type res;
      w = effective_size(cfg_width, MAX_W);
      h = effective_size(cfg_height, MAX_H);
      ci = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
      top = line_mem[ci];
      mid = line_mem[MAX_W + ci];
      row_last = (col_pos + 1 >= w);
      frame_last = row_last && (row_pos + 1 >= h);
      line_mem[ci] = mid;
      line_mem[MAX_W + ci] = pix;
      if (row_pos >= 2 && col_pos >= 2) begin
         ctr = win[1];
         raw = {win[3] >= ctr, win[0] >= ctr, top >= ctr, mid >= ctr,
                pix >= ctr, win[2] >= ctr, win[5] >= ctr, win[4] >= ctr};
         res.code = encode_pattern(raw, cfg_mode);
         res.row_end = row_last;
         res.frame_end = frame_last;
         expected_codes.push_back(res);
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = top;
      win[1] = mid;
      win[2] = pix;
      if (row_last) begin
         col_pos = 0;
         row_pos = frame_last ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // Pixels still needed to close the current frame under the present sizes.
   // Only meaningful while the block is quiet.
   function automatic int remaining_in_frame();
      int w;
      int h;
      int row_rest;
      int more_rows;
      w = effective_size(cfg_width, MAX_W);
      h = effective_size(cfg_height, MAX_H);
      row_rest = (col_pos + 1 >= w) ? 1 : w - int'(col_pos);
      more_rows = (row_pos + 1 >= h) ? 0 : h - 1 - int'(row_pos);
      return row_rest + more_rows * w;
   endfunction

   function automatic logic [31:0] register_image(input reg_index_type idx);
      case (idx)
         REG_IMAGE_WIDTH:  return 32'(cfg_width);
         REG_IMAGE_HEIGHT: return 32'(cfg_height);
         default:          return 32'(cfg_mode);
      endcase
   endfunction

   function automatic logic [7:0] next_pixel(input texture_type tex,
                                             input logic [7:0] base);
      case (tex)
         TEX_UNIFORM: return 8'($urandom_range(255));
         TEX_NARROW:  return base + 8'($urandom_range(2));
         TEX_BINARY:  return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         default:     return base;
      endcase
   endfunction

   function automatic texture_type pick_texture();
      int r;
      r = $urandom_range(9);
      if (r < 4) return TEX_UNIFORM;
      if (r < 7) return TEX_NARROW;
      if (r < 9) return TEX_BINARY;
      return TEX_FLAT;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: pops the next pending pixel when the slot is free and it does not
   // idle at random. The model sees each pixel at the edge where it is accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_window(req_pixel);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= stall_pct) begin
               req_valid <= 1'b1;
               req_pixel <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every accepted code item is matched against the oldest
   // expectation. Ready is thrown at random on each cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $error("code item %0d arrived with nothing expected", rsp_code);
               errors++;
            end else begin
               code_want = expected_codes.pop_front();
               codes_checked++;
               if (rsp_code !== code_want.code) begin
                  $error("code: expected %0d, got %0d", code_want.code, rsp_code);
                  errors++;
               end
               if (rsp_row_end !== code_want.row_end) begin
                  $error("row_end: expected %0b, got %0b", code_want.row_end, rsp_row_end);
                  errors++;
               end
               if (rsp_frame_end !== code_want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b",
                         code_want.frame_end, rsp_frame_end);
                  errors++;
               end
            end
            if (rsp_frame_end === 1'b1) frames_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer helpers.
   // ------------------------------------------------------------------------

   // Quiet means nothing pending, nothing in flight and no code owed. Checked
   // at the falling edge so the driver's updates have settled. Border pixels
   // leave no result behind, hence the extra cycles.
   task automatic wait_quiet();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || expected_codes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(input reg_index_type idx, output logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [31:0] data;
      csr_read(idx, data);
      if (data !== register_image(idx)) begin
         $error("prdata (%s): expected %0d, got %0d", idx.name(), register_image(idx), data);
         errors++;
      end
   endtask

   // The register changes at the access edge; the model copy follows there.
   task automatic csr_write(input reg_index_type idx, input int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = CFG_SIZE_BITS'(value);
         REG_IMAGE_HEIGHT: cfg_height = CFG_SIZE_BITS'(value);
         default:          cfg_mode   = code_mode_type'(value[1:0]);
      endcase
      csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_register(idx);
   endtask

   task automatic push_pixels(input int count, input texture_type tex);
      logic [7:0] base;
      base = 8'($urandom_range(253));
      @(negedge clock);
      for (int i = 0; i < count; i++) pixel_queue.push_back(next_pixel(tex, base));
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h, input code_mode_type m);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_CODE_MODE, m);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin
      int random_pixels;
      int frame_pixels;
      int cut;
      int rest;
      int nframes;
      int r;
      int w_eff;
      texture_type tex;

      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers must read back their reset values.
      check_register(REG_IMAGE_WIDTH);
      check_register(REG_IMAGE_HEIGHT);
      check_register(REG_CODE_MODE);

      // Three short rows at the reset height, then shorten the frame while it
      // is open: the row count is already past the new last row, so the next
      // row ends the frame.
      csr_write(REG_IMAGE_WIDTH, 8);
      push_pixels(3 * effective_size(cfg_width, MAX_W), TEX_UNIFORM);
      wait_quiet();
      csr_write(REG_IMAGE_HEIGHT, 3);
      push_pixels(remaining_in_frame(), TEX_NARROW);
      wait_quiet();

      // Directed 3x3 frames. A flat frame sets every bit.
      set_frame(3, 3, MODE_RAW);
      push_pixels(9, TEX_FLAT);
      wait_quiet();
      // A bright centre over a dark ring clears every bit; the uniform label
      // of the all-zero pattern is its first one.
      csr_write(REG_CODE_MODE, MODE_UNIFORM);
      @(negedge clock);
      for (int i = 0; i < 9; i++) pixel_queue.push_back((i == 4) ? 8'hFF : 8'h00);
      wait_quiet();
      // Sizes of zero act as three. Bright corners around a mid-grey centre
      // give alternating bits, the pattern with the most transitions.
      set_frame(0, 0, MODE_RI_INDEX);
      @(negedge clock);
      for (int i = 0; i < 9; i++)
         pixel_queue.push_back((i == 4) ? 8'd128 : ((i % 2 == 0) ? 8'hFF : 8'h00));
      wait_quiet();

      // A full frame without any idling on either side.
      stall_pct = 0;
      set_frame(40, 5, MODE_RI_MIN);
      push_pixels(40 * 5, TEX_UNIFORM);
      wait_quiet();
      stall_pct = IDLE_PCT;
      // An all-ones width clamps to the build maximum, so one full row at
      // that width ends the first row. The width then shrinks for the rest
      // of the frame, whose rows are numbered from that row end.
      set_frame(2047, 3, MODE_UNIFORM);
      push_pixels(MAX_W, TEX_NARROW);
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, 5);
      push_pixels(remaining_in_frame(), TEX_NARROW);
      wait_quiet();

      // Random phases of mostly small frames. Some registers keep their old
      // value across a phase; the last frame is sometimes cut and resized.
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         wait_quiet();
         stall_pct = ($urandom_range(9) == 0) ? 0 : IDLE_PCT;
         r = $urandom_range(99);
         if (r < 12)
            csr_write(REG_IMAGE_WIDTH, $urandom_range(2));
         else if (r < 85)
            csr_write(REG_IMAGE_WIDTH, $urandom_range(12, 3));
         else if (r < 95)
            csr_write(REG_IMAGE_WIDTH, $urandom_range(40, 13));
         if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 15)
               csr_write(REG_IMAGE_HEIGHT, $urandom_range(2));
            else
               csr_write(REG_IMAGE_HEIGHT, $urandom_range(8, 3));
         end
         if ($urandom_range(99) < 70) csr_write(REG_CODE_MODE, $urandom_range(3));
         w_eff = effective_size(cfg_width, MAX_W);
         frame_pixels = w_eff * effective_size(cfg_height, MAX_H);
         nframes = $urandom_range(3, 1);
         for (int f = 0; f < nframes; f++) begin
            tex = pick_texture();
            if (f == nframes - 1 && $urandom_range(3) == 0) begin
               cut = $urandom_range(frame_pixels - 1, 1);
               push_pixels(cut, tex);
               wait_quiet();
               // Width may only shrink here, so every column read later in
               // this frame has been written by the rows above it.
               if ($urandom_range(1) != 0) csr_write(REG_CODE_MODE, $urandom_range(3));
               if ($urandom_range(1) != 0) csr_write(REG_IMAGE_HEIGHT, $urandom_range(10));
               if ($urandom_range(1) != 0) csr_write(REG_IMAGE_WIDTH, $urandom_range(w_eff));
               rest = remaining_in_frame();
               push_pixels(rest, tex);
               random_pixels += cut + rest;
            end else begin
               push_pixels(frame_pixels, tex);
               random_pixels += frame_pixels;
            end
         end
      end

      // Drain, then give stray results a chance to show up.
      wait_quiet();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_codes.size() != 0) begin
         $error("%0d expected code items never arrived", expected_codes.size());
         errors++;
      end
      $display("Covered %0d pixels, %0d codes in %0d frames, all four code modes.",
               pixels_accepted, codes_checked, frames_seen);
      $display("Made %0d register writes, sizes from the clamped minimum up to the %s",
               csr_writes, "clamped maximum width.");
      if (errors == 0) begin
         $display("lbp_3x3_stream_multimode_top_test: PASS");
      end else begin
         $display("lbp_3x3_stream_multimode_top_test: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("lbp_3x3_stream_multimode_top_test: FAIL");
      $finish;
   end

endmodule
